[design/hsfd_pkg.sv]
// ----------------------------------------------------------------------------
// hsfd_pkg
// Shared types, constants and the CRC-8 step function of the sensor frame
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hsfd_pkg;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // byte positions inside one six-byte frame
   localparam logic [2:0] POS_W0_HI  = 3'd0;
   localparam logic [2:0] POS_W0_LO  = 3'd1;
   localparam logic [2:0] POS_W0_CRC = 3'd2;
   localparam logic [2:0] POS_W1_HI  = 3'd3;
   localparam logic [2:0] POS_W1_LO  = 3'd4;
   localparam logic [2:0] POS_W1_CRC = 3'd5;

   localparam logic KIND_MEAS   = 1'b0;
   localparam logic KIND_SERIAL = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   localparam logic [14:0] TEMP_SCALE  = 15'd21875;
   localparam logic [13:0] HUM_SCALE   = 14'd15625;
   localparam logic [17:0] TEMP_OFFSET = 18'd45000;
   localparam logic [17:0] HUM_OFFSET  = 18'd6000;
   localparam int          FRAC_BITS   = 13;

   typedef struct packed {
      logic        status;
      logic        kind;
      logic [15:0] word0;
      logic [15:0] word1;
   } frame_type;

   // one byte through the msb-first crc, unrolled
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[design/hsfd_frame.sv]
// ----------------------------------------------------------------------------
// hsfd_frame
// Byte assembler: tracks the frame position, runs the CRC-8 check and hands
// each completed frame to the conversion stage through a register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfd_frame (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_rx_byte,
   input  wire logic              req_frame_start,
   input  wire logic              req_mode,
   output logic                   frm_valid,
   input  wire logic              frm_ready,
   output hsfd_pkg::frame_type    frm_data
);

   logic [2:0]          count_ff, count_in;
   logic [7:0]          crc_ff, crc_in;
   logic [15:0]         word0_ff, word0_in;
   logic [15:0]         word1_ff, word1_in;
   logic                err_ff, err_in;
   logic                kind_ff, kind_in;
   logic                frm_valid_ff, frm_valid_in;
   hsfd_pkg::frame_type frame_ff, frame_in;

   logic       accept;
   logic [2:0] pos;
   logic       first;
   logic [7:0] crc_base;
   logic       err_base;

   assign req_ready = !frm_valid_ff || frm_ready;
   assign accept    = req_valid && req_ready;
   assign frm_valid = frm_valid_ff;
   assign frm_data  = frame_ff;

   always_comb begin
      pos = count_ff;
      if (req_frame_start || (count_ff > hsfd_pkg::POS_W1_CRC)) begin
         pos = hsfd_pkg::POS_W0_HI;
      end
      first    = (pos == hsfd_pkg::POS_W0_HI);
      crc_base = first ? hsfd_pkg::CRC_INIT : crc_ff;
      err_base = first ? 1'b0 : err_ff;
      kind_in  = first ? req_mode : kind_ff;

      word0_in = word0_ff;
      word1_in = word1_ff;
      crc_in   = hsfd_pkg::CRC_INIT;
      err_in   = err_base;
      unique case (pos)
         hsfd_pkg::POS_W0_HI, hsfd_pkg::POS_W0_LO: begin
            word0_in = {word0_ff[7:0], req_rx_byte};
            crc_in   = hsfd_pkg::crc8_byte(crc_base, req_rx_byte);
         end
         hsfd_pkg::POS_W1_HI, hsfd_pkg::POS_W1_LO: begin
            word1_in = {word1_ff[7:0], req_rx_byte};
            crc_in   = hsfd_pkg::crc8_byte(crc_base, req_rx_byte);
         end
         default: begin
            err_in = err_base | (crc_base != req_rx_byte);
         end
      endcase

      count_in = (pos == hsfd_pkg::POS_W1_CRC) ? hsfd_pkg::POS_W0_HI : pos + 3'd1;

      frame_in.status = err_in ? hsfd_pkg::STATUS_BAD : hsfd_pkg::STATUS_OK;
      frame_in.kind   = kind_in;
      frame_in.word0  = word0_in;
      frame_in.word1  = word1_in;

      frm_valid_in = frm_valid_ff && !frm_ready;
      if (accept && (pos == hsfd_pkg::POS_W1_CRC)) begin
         frm_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= hsfd_pkg::POS_W0_HI;
         crc_ff       <= hsfd_pkg::CRC_INIT;
         word0_ff     <= '0;
         word1_ff     <= '0;
         err_ff       <= 1'b0;
         kind_ff      <= hsfd_pkg::KIND_MEAS;
         frm_valid_ff <= 1'b0;
      end else begin
         frm_valid_ff <= frm_valid_in;
         if (accept) begin
            count_ff <= count_in;
            crc_ff   <= crc_in;
            word0_ff <= word0_in;
            word1_ff <= word1_in;
            err_ff   <= err_in;
            kind_ff  <= kind_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (pos == hsfd_pkg::POS_W1_CRC)) begin
         frame_ff <= frame_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= hsfd_pkg::POS_W1_CRC)
      else $error("byte count out of range");

   a_last_byte_emits: assert property (@(posedge clock) disable iff (reset)
      accept && (pos == hsfd_pkg::POS_W1_CRC) |=> frm_valid_ff && (count_ff == 3'd0))
      else $error("last byte did not produce a frame");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      accept && !req_frame_start && (count_ff < hsfd_pkg::POS_W1_CRC)
      |=> count_ff == $past(count_ff) + 3'd1)
      else $error("byte count did not advance");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      frm_valid_ff && !frm_ready |-> !req_ready)
      else $error("pending frame could be overwritten");

endmodule

`default_nettype wire

[design/hsfd_convert.sv]
// ----------------------------------------------------------------------------
// hsfd_convert
// Result stage: scales measurement words or joins the serial words (zero on a
// CRC mismatch) and holds the result register toward the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfd_convert (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                frm_valid,
   output logic                     frm_ready,
   input  wire hsfd_pkg::frame_type frm_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_status,
   output logic                     rsp_frame_kind,
   output logic signed [17:0]       rsp_temperature_milli_c,
   output logic signed [17:0]       rsp_humidity_milli_pct,
   output logic [31:0]              rsp_serial_number
);

   logic               valid_ff, valid_in;
   logic               status_ff;
   logic               kind_ff;
   logic signed [17:0] temp_ff, temp_in;
   logic signed [17:0] hum_ff, hum_in;
   logic [31:0]        serial_ff, serial_in;

   logic        load;
   logic        good;
   logic [30:0] temp_prod;
   logic [29:0] hum_prod;
   logic [17:0] temp_scaled;
   logic [16:0] hum_scaled;

   assign frm_ready = !valid_ff || rsp_ready;
   assign load      = frm_valid && frm_ready;

   always_comb begin
      good        = (frm_data.status == hsfd_pkg::STATUS_OK);
      temp_prod   = 31'(hsfd_pkg::TEMP_SCALE) * 31'(frm_data.word0);
      hum_prod    = 30'(hsfd_pkg::HUM_SCALE) * 30'(frm_data.word1);
      temp_scaled = temp_prod[30:hsfd_pkg::FRAC_BITS];
      hum_scaled  = hum_prod[29:hsfd_pkg::FRAC_BITS];

      temp_in   = '0;
      hum_in    = '0;
      serial_in = '0;
      if (good && (frm_data.kind == hsfd_pkg::KIND_MEAS)) begin
         temp_in = signed'(temp_scaled - hsfd_pkg::TEMP_OFFSET);
         hum_in  = signed'({1'b0, hum_scaled} - hsfd_pkg::HUM_OFFSET);
      end
      if (good && (frm_data.kind == hsfd_pkg::KIND_SERIAL)) begin
         serial_in = {frm_data.word0, frm_data.word1};
      end

      valid_in = valid_ff && !rsp_ready;
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= frm_data.status;
         kind_ff   <= frm_data.kind;
         temp_ff   <= temp_in;
         hum_ff    <= hum_in;
         serial_ff <= serial_in;
      end
   end

   assign rsp_valid               = valid_ff;
   assign rsp_status              = status_ff;
   assign rsp_frame_kind          = kind_ff;
   assign rsp_temperature_milli_c = temp_ff;
   assign rsp_humidity_milli_pct  = hum_ff;
   assign rsp_serial_number       = serial_ff;

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (status_ff == hsfd_pkg::STATUS_BAD)
      |-> (temp_ff == '0) && (hum_ff == '0) && (serial_ff == '0))
      else $error("mismatch result carries data");

   a_serial_no_meas: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (kind_ff == hsfd_pkg::KIND_SERIAL) |-> (temp_ff == '0) && (hum_ff == '0))
      else $error("serial result carries measurement");

   a_meas_no_serial: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (kind_ff == hsfd_pkg::KIND_MEAS) |-> serial_ff == '0)
      else $error("measurement result carries serial");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff && (status_ff == $past(frm_data.status)))
      else $error("frame not moved to result register");

endmodule

`default_nettype wire

[design/humidity_sensor_frame_decoder_unit.sv]
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_unit
// Six-byte sensor frame decoder: CRC-8 check of both words, then conversion
// to milli-degrees and milli-percent, or a 32-bit serial number.
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_ready   rx_byte, frame_start, mode
//   rsp_      out         rsp_valid / rsp_ready   status, frame_kind,
//                                                 temperature, humidity, serial
//
// one request byte per cycle while req_ready is high; the byte-wide crc is unrolled in the assembler
// after its sixth byte is taken, a result goes through the frame register,
// then the constant multipliers into the result register
// reset clears byte count, crc, words and both valid registers
// a stalled result holds both stages; bytes of an unfinished frame still
// pass while the frame register is empty or draining
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_sensor_frame_decoder_unit (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [7:0]    req_rx_byte,
   input  wire logic          req_frame_start,
   input  wire logic          req_mode,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic               rsp_status,
   output logic               rsp_frame_kind,
   output logic signed [17:0] rsp_temperature_milli_c,
   output logic signed [17:0] rsp_humidity_milli_pct,
   output logic [31:0]        rsp_serial_number
);

   logic                frm_valid;
   logic                frm_ready;
   hsfd_pkg::frame_type frm_data;

   hsfd_frame u_frame (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .req_frame_start (req_frame_start),
      .req_mode        (req_mode),
      .frm_valid       (frm_valid),
      .frm_ready       (frm_ready),
      .frm_data        (frm_data)
   );

   hsfd_convert u_convert (
      .clock                   (clock),
      .reset                   (reset),
      .frm_valid               (frm_valid),
      .frm_ready               (frm_ready),
      .frm_data                (frm_data),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_status              (rsp_status),
      .rsp_frame_kind          (rsp_frame_kind),
      .rsp_temperature_milli_c (rsp_temperature_milli_c),
      .rsp_humidity_milli_pct  (rsp_humidity_milli_pct),
      .rsp_serial_number       (rsp_serial_number)
   );

endmodule

`default_nettype wire
